@@ src/intel_hex_record_parser_core_macros.svh @@
// Assertion macros shared by the parser RTL.
`ifndef INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define IHEX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IHEX_ASSERT(lbl, clk, rst_n, prop, msg)
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/ihex_pkg.sv @@
package ihex_pkg;

    localparam int DEF_MAX_LINE_CHARS = 1024;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    localparam int HDR_CHARS = 11;

    typedef enum logic [2:0] {
        KIND_DATA = 3'd0,
        KIND_DONE = 3'd1,
        KIND_DROP = 3'd2,
        KIND_EXEC = 3'd3,
        KIND_EOF  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] address;
        logic [7:0]  byte_value;
        logic [7:0]  record_length;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            n = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            n = 4'(c[3:0] + 4'd9);
        end
        return n;
    endfunction

endpackage

@@ src/ihex_line.sv @@
`include "intel_hex_record_parser_core_macros.svh"

module ihex_line #(
    parameter int MAX_LINE_CHARS = ihex_pkg::DEF_MAX_LINE_CHARS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char,
    output logic              o_res_valid,
    output ihex_pkg::t_result o_res
);
    import ihex_pkg::*;

    localparam int CW = $clog2(MAX_LINE_CHARS + 1);
    localparam int LW = (CW > 9) ? CW + 1 : 10;

    logic [CW-1:0] r_char_count, n_char_count;
    logic          r_start_ok, n_start_ok;
    logic [7:0]    r_length, n_length;
    logic [15:0]   r_offset, n_offset;
    logic [7:0]    r_type, n_type;
    logic [15:0]   r_accum, n_accum;
    logic [7:0]    r_byte_index, n_byte_index;
    logic [31:0]   r_first, n_first;
    logic [31:0]   r_base, n_base;
    logic          r_finished, n_finished;

    logic [15:0]   accum_next;
    logic [7:0]    cur_byte;
    logic [LW-1:0] len2;
    logic [LW-1:0] room;
    logic          line_ok;

    always_comb begin
        n_char_count = r_char_count;
        n_start_ok   = r_start_ok;
        n_length     = r_length;
        n_offset     = r_offset;
        n_type       = r_type;
        n_accum      = r_accum;
        n_byte_index = r_byte_index;
        n_first      = r_first;
        n_base       = r_base;
        n_finished   = r_finished;
        o_res_valid  = 1'b0;
        o_res.kind          = KIND_DONE;
        o_res.address       = 32'd0;
        o_res.byte_value    = 8'd0;
        o_res.record_length = r_length;

        accum_next = {r_accum[11:0], hex_nibble(i_char)};
        cur_byte   = accum_next[7:0];
        len2       = LW'({r_length, 1'b0});
        room       = LW'(r_char_count) - LW'(HDR_CHARS - 1);
        line_ok    = r_start_ok && (r_char_count >= CW'(HDR_CHARS - 1)) && (len2 <= room);

        if (i_accept && !r_finished) begin
            if (i_char == CHAR_LF) begin
                o_res_valid = 1'b1;
                if (!line_ok) begin
                    o_res.kind = KIND_DROP;
                end else if (r_type == REC_EOF) begin
                    o_res.kind = KIND_EOF;
                    n_finished = 1'b1;
                end else if (r_type == REC_SLA) begin
                    o_res.kind    = KIND_EXEC;
                    o_res.address = r_first;
                end else begin
                    if (r_type == REC_ELA) begin
                        n_base = {r_first[31:16], 16'd0};
                    end
                end
                n_char_count = '0;
                n_start_ok   = 1'b0;
                n_length     = 8'd0;
                n_offset     = 16'd0;
                n_type       = 8'd0;
                n_accum      = 16'd0;
                n_byte_index = 8'd0;
                n_first      = 32'd0;
            end else if (r_char_count < CW'(MAX_LINE_CHARS)) begin
                n_char_count = r_char_count + CW'(1);
                if (r_char_count == '0) begin
                    n_start_ok = (i_char == CHAR_COLON);
                end else begin
                    n_accum = accum_next;
                    if (r_char_count == CW'(2)) begin
                        n_length = cur_byte;
                    end else if (r_char_count == CW'(6)) begin
                        n_offset = accum_next;
                    end else if (r_char_count == CW'(8)) begin
                        n_type = cur_byte;
                    end else if (r_char_count >= CW'(10) && !r_char_count[0]) begin
                        if (r_byte_index < r_length) begin
                            case (r_byte_index)
                                8'd0:    n_first[31:24] = cur_byte;
                                8'd1:    n_first[23:16] = cur_byte;
                                8'd2:    n_first[15:8]  = cur_byte;
                                8'd3:    n_first[7:0]   = cur_byte;
                                default: n_first        = r_first;
                            endcase
                            if (r_type == REC_DATA) begin
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_DATA;
                                o_res.address    = r_base + {16'd0, r_offset}
                                                 + {24'd0, r_byte_index};
                                o_res.byte_value = cur_byte;
                            end
                        end
                        if (r_byte_index != 8'hFF) begin
                            n_byte_index = r_byte_index + 8'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_start_ok   <= 1'b0;
            r_length     <= 8'd0;
            r_offset     <= 16'd0;
            r_type       <= 8'd0;
            r_accum      <= 16'd0;
            r_byte_index <= 8'd0;
            r_first      <= 32'd0;
            r_base       <= 32'd0;
            r_finished   <= 1'b0;
        end else begin
            r_char_count <= n_char_count;
            r_start_ok   <= n_start_ok;
            r_length     <= n_length;
            r_offset     <= n_offset;
            r_type       <= n_type;
            r_accum      <= n_accum;
            r_byte_index <= n_byte_index;
            r_first      <= n_first;
            r_base       <= n_base;
            r_finished   <= n_finished;
        end
    end

    `IHEX_ASSERT(a_finished_sticky, i_clk, i_rst_n,
                 r_finished |=> r_finished, "end of file flag cleared")
    `IHEX_ASSERT(a_data_only_type0, i_clk, i_rst_n,
                 (o_res_valid && o_res.kind == KIND_DATA) |-> (r_type == REC_DATA),
                 "data beat from non-data record")
    `IHEX_ASSERT(a_count_bounded, i_clk, i_rst_n,
                 r_char_count <= CW'(MAX_LINE_CHARS), "line counter overran")
    `IHEX_ASSERT(a_silent_after_eof, i_clk, i_rst_n,
                 r_finished |-> !o_res_valid, "result after end of file")

endmodule

@@ src/ihex_obuf.sv @@
`include "intel_hex_record_parser_core_macros.svh"

module ihex_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihex_pkg::t_result i_res,
    output logic              o_push_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output ihex_pkg::t_result o_res
);
    import ihex_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    always_comb begin
        pop          = r_main_valid && i_ready;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_res;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_res        = r_main;

    `IHEX_ASSERT(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid |-> r_main_valid, "skid full with main empty")
    `IHEX_ASSERT(a_empty_no_skid, i_clk, i_rst_n, !r_main_valid |=> !r_skid_valid, "skid filled past empty main")
    `IHEX_ASSERT(a_stall_to_skid, i_clk, i_rst_n, (i_push && r_main_valid && !i_ready && !r_skid_valid) |=> r_skid_valid, "stalled beat lost")

endmodule

@@ src/intel_hex_record_parser_core.sv @@
// Intel HEX parser: takes one character of hex text per beat, every cycle while
// the input is not stalled, and gives at most one result per character. Data
// bytes of type 00 records leave as soon as their second digit arrives; the
// newline gives record done, dropped (discard that record's bytes), exec address
// or end of file, after which input is swallowed until reset. Throughput is one
// character per clock while not stalled, set by the line decoder, which decodes
// combinationally. A main and a skid beat at the output catch a result while the
// sink stalls; once both are held the input stalls until the cycle after the sink takes a beat.
module intel_hex_record_parser_core #(
    parameter int MAX_LINE_CHARS = ihex_pkg::DEF_MAX_LINE_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_in[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // address[31:0], byte_value[39:32], record_length[47:40]
    output logic [2:0]  o_m_axis_tuser    // kind[2:0]
);
    import ihex_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    ihex_line #(
        .MAX_LINE_CHARS(MAX_LINE_CHARS)
    ) u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ihex_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_res        (res),
        .o_push_ready (o_s_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_res        (out_res)
    );

    assign o_m_axis_tdata = {out_res.record_length, out_res.byte_value, out_res.address};
    assign o_m_axis_tuser = out_res.kind;

endmodule
